[rtl/edfvd_pkg.sv]
// ----------------------------------------------------------------------------
// edfvd_pkg
// Shared types, codes and helpers of the EDF-VD mixed-criticality scheduler.
// ----------------------------------------------------------------------------
package edfvd_pkg;

  // Default sizing
  localparam int MAX_TASKS_DEF  = 16;
  localparam int TIME_WIDTH_DEF = 32;

  // Item operations
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_TICK = 1'b1;

  // Job status codes
  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_READY = 2'd1;
  localparam logic [1:0] ST_RUN   = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] CFG_QUANTUM = 2'd0;
  localparam logic [1:0] CFG_LAMBDA  = 2'd1;
  localparam logic [1:0] CFG_TCOUNT  = 2'd2;

  // Outcome counter slots
  localparam int CNT_DONE_LOW    = 0;
  localparam int CNT_DONE_HIGH   = 1;
  localparam int CNT_MISSED_LOW  = 2;
  localparam int CNT_MISSED_HIGH = 3;
  localparam int CNT_SWITCH      = 4;
  localparam int CNT_NUM         = 5;

  // Control from the sequencer to the head cell
  typedef struct packed {
    logic en;         // entry lies inside the table in use
    logic do_switch;  // mode switch pass
    logic do_dline;   // completion and deadline pass
    logic do_rel;     // release pass
    logic is_cur;     // entry is the running job
    logic done;       // running job met its demand
    logic mode;       // high mode
    logic set_ready;
    logic set_run;
    logic incr;       // count one execution tick
    logic load_wr;    // write the loaded task
  } ctl_t;

  // Events from the head cell back to the sequencer
  typedef struct packed {
    logic       bump;     // one job finished
    logic [1:0] kind;     // {missed, high}: outcome counter slot
    logic       clr_cur;  // running job stopped
  } evt_t;

  // Saturating counter add
  function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [1:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {31'd0, b};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

endpackage

[rtl/edfvd_cell.sv]
// ----------------------------------------------------------------------------
// edfvd_cell
// One position of the rotating task ring: holds a full task entry and passes
// it on to its neighbour every cycle.
// ----------------------------------------------------------------------------
module edfvd_cell #(
  parameter int TIME_WIDTH = edfvd_pkg::TIME_WIDTH_DEF
) (
  input  logic                  clk_i,
  input  logic [15:0]           period_i,
  input  logic [15:0]           budget_i,
  input  logic                  high_i,
  input  logic [1:0]            status_i,
  input  logic [15:0]           exec_i,
  input  logic [TIME_WIDTH-1:0] rel_i,
  input  logic [TIME_WIDTH-1:0] hd_i,
  input  logic [TIME_WIDTH-1:0] vd_i,
  output logic [15:0]           period_o,
  output logic [15:0]           budget_o,
  output logic                  high_o,
  output logic [1:0]            status_o,
  output logic [15:0]           exec_o,
  output logic [TIME_WIDTH-1:0] rel_o,
  output logic [TIME_WIDTH-1:0] hd_o,
  output logic [TIME_WIDTH-1:0] vd_o
);

  // Entry payload, undefined until a load reaches it
  always_ff @(posedge clk_i) begin
    period_o <= period_i;
    budget_o <= budget_i;
    high_o   <= high_i;
    status_o <= status_i;
    exec_o   <= exec_i;
    rel_o    <= rel_i;
    hd_o     <= hd_i;
    vd_o     <= vd_i;
  end

endmodule

[rtl/edfvd_head.sv]
// ----------------------------------------------------------------------------
// edfvd_head
// Update logic for the entry at the head of the ring: load, mode switch,
// completion and deadline checks, release, and status changes.
// ----------------------------------------------------------------------------
module edfvd_head #(
  parameter int TIME_WIDTH = edfvd_pkg::TIME_WIDTH_DEF
) (
  input  edfvd_pkg::ctl_t       ctl_i,
  input  logic [TIME_WIDTH-1:0] now_i,
  input  logic [16:0]           scaled_i,
  input  logic [15:0]           ld_period_i,
  input  logic [15:0]           ld_budget_i,
  input  logic                  ld_high_i,
  input  logic [15:0]           period_i,
  input  logic [15:0]           budget_i,
  input  logic                  high_i,
  input  logic [1:0]            status_i,
  input  logic [15:0]           exec_i,
  input  logic [TIME_WIDTH-1:0] rel_i,
  input  logic [TIME_WIDTH-1:0] hd_i,
  input  logic [TIME_WIDTH-1:0] vd_i,
  output logic [15:0]           period_o,
  output logic [15:0]           budget_o,
  output logic                  high_o,
  output logic [1:0]            status_o,
  output logic [15:0]           exec_o,
  output logic [TIME_WIDTH-1:0] rel_o,
  output logic [TIME_WIDTH-1:0] hd_o,
  output logic [TIME_WIDTH-1:0] vd_o,
  output edfvd_pkg::evt_t       evt_o
);
  import edfvd_pkg::*;

  logic                  fin;
  logic                  fin_ok;
  logic [TIME_WIDTH-1:0] rel_per;

  assign rel_per = rel_i + TIME_WIDTH'(period_i);

  always_comb begin
    period_o = period_i;
    budget_o = budget_i;
    high_o   = high_i;
    status_o = status_i;
    exec_o   = exec_i;
    rel_o    = rel_i;
    hd_o     = hd_i;
    vd_o     = vd_i;
    evt_o    = '0;
    fin      = 1'b0;
    fin_ok   = 1'b0;

    if (ctl_i.load_wr) begin
      // new task entry, first job released now
      period_o = ld_period_i;
      budget_o = ld_budget_i;
      high_o   = ld_high_i;
      status_o = ST_READY;
      exec_o   = '0;
      rel_o    = now_i;
      hd_o     = now_i + TIME_WIDTH'(ld_period_i);
      vd_o     = ld_high_i ? now_i + TIME_WIDTH'(scaled_i) : now_i + TIME_WIDTH'(ld_period_i);
    end else if (ctl_i.do_switch) begin
      // entering high mode: high jobs fall back to real deadlines, low jobs dropped
      if (ctl_i.en && status_i != ST_IDLE) begin
        if (high_i) begin
          vd_o = rel_per;
        end else begin
          fin           = 1'b1;
          evt_o.clr_cur = ctl_i.is_cur;
        end
      end
    end else if (ctl_i.do_dline) begin
      // completion of the running job, then late jobs
      if (ctl_i.is_cur && ctl_i.done) begin
        fin           = 1'b1;
        fin_ok        = 1'b1;
        evt_o.clr_cur = 1'b1;
      end else if (ctl_i.en && (status_i == ST_READY || status_i == ST_RUN) &&
                   now_i > hd_i) begin
        fin           = 1'b1;
        evt_o.clr_cur = ctl_i.is_cur;
      end
    end else if (ctl_i.do_rel) begin
      // release of due jobs
      if (ctl_i.en && status_i == ST_IDLE && now_i >= rel_i) begin
        if (ctl_i.mode && !high_i) begin
          fin = 1'b1;
        end else begin
          status_o = ST_READY;
          vd_o     = (!ctl_i.mode && high_i) ? rel_i + TIME_WIDTH'(scaled_i) : rel_per;
          hd_o     = rel_per;
        end
      end
    end else begin
      if (ctl_i.set_ready) begin
        status_o = ST_READY;
      end
      if (ctl_i.set_run) begin
        status_o = ST_RUN;
      end
      if (ctl_i.incr && exec_i != 16'hFFFF) begin
        exec_o = exec_i + 16'd1;
      end
    end

    // job finished: back to idle, next release one period on
    if (fin) begin
      status_o   = ST_IDLE;
      rel_o      = rel_per;
      exec_o     = '0;
      evt_o.bump = 1'b1;
      evt_o.kind = {!fin_ok, high_i};
    end
  end

endmodule

[rtl/edfvd_rem.sv]
// ----------------------------------------------------------------------------
// edfvd_rem
// Bit-serial restoring remainder: time modulo quantum, one dividend bit per
// cycle.
// ----------------------------------------------------------------------------
module edfvd_rem #(
  parameter int TIME_WIDTH = edfvd_pkg::TIME_WIDTH_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [TIME_WIDTH-1:0] dividend_i,
  input  logic [15:0]           divisor_i,
  output logic                  done_o,
  output logic [15:0]           rem_o
);

  localparam int CW = $clog2(TIME_WIDTH + 1);

  logic                  busy_q, busy_d;
  logic                  done_q, done_d;
  logic [CW-1:0]         cnt_q, cnt_d;
  logic [TIME_WIDTH-1:0] dvd_q, dvd_d;
  logic [15:0]           dvs_q, dvs_d;
  logic [15:0]           r_q, r_d;
  logic [16:0]           trial;

  // One restoring step
  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    dvd_d  = dvd_q;
    dvs_d  = dvs_q;
    r_d    = r_q;
    trial  = {r_q, dvd_q[TIME_WIDTH-1]};
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CW'(TIME_WIDTH);
      dvd_d  = dividend_i;
      dvs_d  = divisor_i;
      r_d    = '0;
    end else if (busy_q) begin
      if (trial >= {1'b0, dvs_q}) begin
        trial = trial - {1'b0, dvs_q};
      end
      r_d   = trial[15:0];
      dvd_d = dvd_q << 1;
      cnt_d = cnt_q - CW'(1);
      if (cnt_q == CW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    dvs_q <= dvs_d;
    r_q   <= r_d;
  end

  assign done_o = done_q;
  assign rem_o  = r_q;

endmodule

[rtl/edf_vd_mixed_criticality_scheduler.sv]
// ----------------------------------------------------------------------------
// edf_vd_mixed_criticality_scheduler
// EDF-VD scheduler for periodic mixed-criticality tasks, task table held in a
// rotating ring of cells with one shared update unit at its head.
// ----------------------------------------------------------------------------
// Usage:
//   An item is taken when start_i is high and busy_o is low. op_i = 0 loads
//   one task entry, op_i = 1 is one time tick (running_done_i applies).
//   Each item gives one result, shown for one cycle with valid_o high; the
//   receiver takes it in that cycle and cannot stall it.
//   Configuration (quantum, lambda, task count) is written on the cfg channel,
//   always ready; the user must do so only while the block is idle (not enforced).
// Sequencing: the ring rotates continuously and each scan of the table is
//   one rotation, aligned to entry 0.
//   Load: waits for the entry to reach the head.
//   Tick without decision: align, fetch scan, update scan.
//   Tick with decision: align plus up to seven scans.
//   The first tick after a nonzero quantum write first runs the
//   time-modulo-quantum remainder unit.
// Reset: time, mode, running job and counters clear; the task table is
//   undefined until loaded.
// ----------------------------------------------------------------------------
module edf_vd_mixed_criticality_scheduler #(
  parameter int MAX_TASKS  = edfvd_pkg::MAX_TASKS_DEF,
  parameter int TIME_WIDTH = edfvd_pkg::TIME_WIDTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // item channel
  input  logic        start_i,
  output logic        busy_o,
  input  logic        op_i,
  input  logic [3:0]  task_index_i,
  input  logic [15:0] period_i,
  input  logic [15:0] low_budget_i,
  input  logic        high_crit_i,
  input  logic        running_done_i,
  // configuration channel
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [16:0] cfg_data_i,
  // result
  output logic        valid_o,
  output logic        running_valid_o,
  output logic [3:0]  running_task_o,
  output logic        high_mode_o,
  output logic [31:0] done_low_o,
  output logic [31:0] done_high_o,
  output logic [31:0] missed_low_o,
  output logic [31:0] missed_high_o,
  output logic [31:0] switch_count_o
);
  import edfvd_pkg::*;

  localparam int IW  = $clog2(MAX_TASKS);
  localparam int CNW = ((IW > 5) ? IW : 5) + 1;
  localparam int TW  = TIME_WIDTH;

  // Sequencer states
  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_REM    = 4'd1;
  localparam logic [3:0] S_ALIGN  = 4'd2;
  localparam logic [3:0] S_FETCH  = 4'd3;
  localparam logic [3:0] S_SWITCH = 4'd4;
  localparam logic [3:0] S_DLINE  = 4'd5;
  localparam logic [3:0] S_REL    = 4'd6;
  localparam logic [3:0] S_SEL    = 4'd7;
  localparam logic [3:0] S_COMMIT = 4'd8;
  localparam logic [3:0] S_RESEL  = 4'd9;
  localparam logic [3:0] S_RUN    = 4'd10;
  localparam logic [3:0] S_LOAD   = 4'd11;
  localparam logic [3:0] S_OUT    = 4'd12;

  // Ring of cells
  logic [15:0]   c_period [MAX_TASKS];
  logic [15:0]   c_budget [MAX_TASKS];
  logic          c_high   [MAX_TASKS];
  logic [1:0]    c_status [MAX_TASKS];
  logic [15:0]   c_exec   [MAX_TASKS];
  logic [TW-1:0] c_rel    [MAX_TASKS];
  logic [TW-1:0] c_hd     [MAX_TASKS];
  logic [TW-1:0] c_vd     [MAX_TASKS];

  // Head cell output
  logic [15:0]   h_period, h_budget, h_exec;
  logic          h_high;
  logic [1:0]    h_status;
  logic [TW-1:0] h_rel, h_hd, h_vd;
  ctl_t          ctl;
  evt_t          evt;

  // Control and status registers
  logic [3:0]    state_q, state_d;
  logic [IW-1:0] hidx_q, hidx_d;
  logic [TW-1:0] now_q, now_d;
  logic [15:0]   rem_q, rem_d;
  logic          stale_q, stale_d;
  logic          mode_q, mode_d;
  logic          cv_q, cv_d;
  logic [IW-1:0] cur_q, cur_d;
  logic [31:0]   cnt_q [CNT_NUM];
  logic [31:0]   cnt_d [CNT_NUM];
  logic [15:0]   quantum_q;
  logic [16:0]   lambda_q;
  logic [4:0]    tcount_q;
  logic          primed_q, primed_d;
  logic          dem_q, dem_d;
  logic          mv_q, mv_d;
  logic [IW-1:0] m_q, m_d;
  logic [TW-1:0] vdm_q, vdm_d;
  logic [IW-1:0] old_q, old_d;
  logic          oldv_q, oldv_d;

  // Item and capture payload
  logic          ld_op_q, ld_done_q, ld_high_q;
  logic [3:0]    ld_idx_q;
  logic [15:0]   ld_period_q, ld_budget_q;
  logic [15:0]   cx_exec_q, cx_exec_d, cx_budget_q, cx_budget_d;
  logic [TW-1:0] cx_hd_q, cx_hd_d, cx_vd_q, cx_vd_d;
  logic          cx_high_q, cx_high_d;
  logic [16:0]   scaled_q;

  logic          accept, last, hit, en, idx_ok, ld_hit;
  logic [CNW-1:0] n_w;
  logic [15:0]   mul_per;
  logic [32:0]   prod;
  logic          rem_start, rem_done;
  logic [15:0]   rem_res;
  logic          boundary, over, evnt;

  genvar gk;
  generate
    for (gk = 0; gk < MAX_TASKS; gk++) begin : g_ring
      if (gk == MAX_TASKS - 1) begin : g_tail
        edfvd_cell #(.TIME_WIDTH(TW)) u_cell (
          .clk_i   (clk_i),
          .period_i(h_period), .budget_i(h_budget), .high_i(h_high),
          .status_i(h_status), .exec_i(h_exec), .rel_i(h_rel), .hd_i(h_hd),
          .vd_i    (h_vd),
          .period_o(c_period[gk]), .budget_o(c_budget[gk]), .high_o(c_high[gk]),
          .status_o(c_status[gk]), .exec_o(c_exec[gk]), .rel_o(c_rel[gk]),
          .hd_o    (c_hd[gk]), .vd_o(c_vd[gk])
        );
      end else begin : g_body
        edfvd_cell #(.TIME_WIDTH(TW)) u_cell (
          .clk_i   (clk_i),
          .period_i(c_period[gk+1]), .budget_i(c_budget[gk+1]), .high_i(c_high[gk+1]),
          .status_i(c_status[gk+1]), .exec_i(c_exec[gk+1]), .rel_i(c_rel[gk+1]),
          .hd_i    (c_hd[gk+1]), .vd_i(c_vd[gk+1]),
          .period_o(c_period[gk]), .budget_o(c_budget[gk]), .high_o(c_high[gk]),
          .status_o(c_status[gk]), .exec_o(c_exec[gk]), .rel_o(c_rel[gk]),
          .hd_o    (c_hd[gk]), .vd_o(c_vd[gk])
        );
      end
    end
  endgenerate

  edfvd_head #(.TIME_WIDTH(TW)) u_head (
    .ctl_i      (ctl),
    .now_i      (now_q),
    .scaled_i   (scaled_q),
    .ld_period_i(ld_period_q),
    .ld_budget_i(ld_budget_q),
    .ld_high_i  (ld_high_q),
    .period_i   (c_period[0]), .budget_i(c_budget[0]), .high_i(c_high[0]),
    .status_i   (c_status[0]), .exec_i(c_exec[0]), .rel_i(c_rel[0]),
    .hd_i       (c_hd[0]), .vd_i(c_vd[0]),
    .period_o   (h_period), .budget_o(h_budget), .high_o(h_high),
    .status_o   (h_status), .exec_o(h_exec), .rel_o(h_rel), .hd_o(h_hd), .vd_o(h_vd),
    .evt_o      (evt)
  );

  edfvd_rem #(.TIME_WIDTH(TW)) u_rem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (rem_start),
    .dividend_i(now_q),
    .divisor_i (quantum_q),
    .done_o    (rem_done),
    .rem_o     (rem_res)
  );

  // Scaled period for the entry arriving at the head next cycle
  assign mul_per = (state_q == S_LOAD) ? ld_period_q : c_period[1];
  assign prod    = 33'(mul_per) * 33'(lambda_q);

  // Ring position and common decodes
  assign accept  = start_i && (state_q == S_IDLE);
  assign last    = (hidx_q == IW'(MAX_TASKS - 1));
  assign hit     = (hidx_q == cur_q);
  assign n_w     = (CNW'(tcount_q) > CNW'(MAX_TASKS)) ? CNW'(MAX_TASKS) : CNW'(tcount_q);
  assign en      = (CNW'(hidx_q) < n_w);
  assign idx_ok  = (CNW'(ld_idx_q) < CNW'(MAX_TASKS));
  assign ld_hit  = (CNW'(hidx_q) == CNW'(ld_idx_q));
  assign hidx_d  = last ? '0 : hidx_q + IW'(1);
  assign rem_start = accept && (op_i == OP_TICK) && stale_q && (quantum_q != 16'd0);

  // Running job fields from the fetch scan, its vd from the release scan
  assign cx_exec_d   = (state_q == S_FETCH && hit) ? c_exec[0]   : cx_exec_q;
  assign cx_budget_d = (state_q == S_FETCH && hit) ? c_budget[0] : cx_budget_q;
  assign cx_hd_d     = (state_q == S_FETCH && hit) ? c_hd[0]     : cx_hd_q;
  assign cx_high_d   = (state_q == S_FETCH && hit) ? c_high[0]   : cx_high_q;
  assign cx_vd_d     = (state_q == S_REL && hit)   ? h_vd        : cx_vd_q;

  assign boundary = (quantum_q == 16'd0) || (rem_q == 16'd0);
  assign over     = !mode_q && (cx_exec_d > cx_budget_d);
  assign evnt     = cv_q && (ld_done_q || over || (now_q > cx_hd_d));

  // Head control per scan
  always_comb begin
    ctl      = '0;
    ctl.en   = en;
    ctl.mode = mode_q;
    ctl.done = ld_done_q;
    ctl.is_cur = cv_q && hit;
    case (state_q)
      S_SWITCH: ctl.do_switch = 1'b1;
      S_DLINE:  ctl.do_dline  = 1'b1;
      S_REL:    ctl.do_rel    = 1'b1;
      S_SEL:    ctl.set_ready = dem_q && hit;
      S_COMMIT: begin
        ctl.set_ready = oldv_q && (hidx_q == old_q);
        ctl.set_run   = hit;
        ctl.incr      = hit;
      end
      S_RUN: begin
        ctl.set_run = cv_q && hit;
        ctl.incr    = cv_q && hit;
      end
      S_LOAD:   ctl.load_wr = primed_q && idx_ok && ld_hit;
      default:  ctl.en = en;
    endcase
  end

  // Sequencer
  always_comb begin
    state_d  = state_q;
    now_d    = now_q;
    rem_d    = rem_q;
    stale_d  = stale_q;
    mode_d   = mode_q;
    cv_d     = cv_q;
    cur_d    = cur_q;
    primed_d = primed_q;
    dem_d    = dem_q;
    mv_d     = mv_q;
    m_d      = m_q;
    vdm_d    = vdm_q;
    old_d    = old_q;
    oldv_d   = oldv_q;
    for (int k = 0; k < CNT_NUM; k++) begin
      cnt_d[k] = cnt_q[k];
    end

    // finished jobs
    if (evt.bump) begin
      for (int k = 0; k < 4; k++) begin
        if (evt.kind == 2'(k)) begin
          cnt_d[k] = sat_add(cnt_q[k], 2'd1);
        end
      end
    end
    if (evt.clr_cur) begin
      cv_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        primed_d = 1'b0;
        if (accept) begin
          if (op_i == OP_LOAD) begin
            state_d = S_LOAD;
          end else if (rem_start) begin
            state_d = S_REM;
          end else begin
            state_d = S_ALIGN;
          end
        end
      end
      S_REM: begin
        if (rem_done) begin
          rem_d   = rem_res;
          stale_d = 1'b0;
          state_d = S_ALIGN;
        end
      end
      S_ALIGN: begin
        if (last) begin
          state_d = S_FETCH;
        end
      end
      S_FETCH: begin
        if (last) begin
          if (boundary || evnt) begin
            cnt_d[CNT_SWITCH] = sat_add(cnt_q[CNT_SWITCH], 2'd2);
            if (cv_q && !ld_done_q && over) begin
              mode_d  = 1'b1;
              state_d = S_SWITCH;
            end else begin
              state_d = S_DLINE;
            end
          end else begin
            state_d = S_RUN;
          end
        end
      end
      S_SWITCH: begin
        if (last) begin
          state_d = S_DLINE;
        end
      end
      S_DLINE: begin
        if (last) begin
          state_d = S_REL;
        end
      end
      S_REL: begin
        if (last) begin
          // a running low job in high mode goes back to ready
          dem_d   = mode_q && cv_q && !cx_high_q;
          cv_d    = cv_q && !(mode_q && !cx_high_q);
          mv_d    = cv_q && !(mode_q && !cx_high_q);
          m_d     = cur_q;
          vdm_d   = cx_vd_d;
          state_d = S_SEL;
        end
      end
      S_SEL: begin
        // earliest scheduling deadline among eligible ready jobs
        if (en && h_status == ST_READY && (!mode_q || h_high) &&
            (!mv_q || h_vd < vdm_q)) begin
          mv_d  = 1'b1;
          m_d   = hidx_q;
          vdm_d = h_vd;
        end
        if (last) begin
          if (mv_d && (!cv_q || m_d != cur_q)) begin
            old_d   = cur_q;
            oldv_d  = cv_q;
            cur_d   = m_d;
            cv_d    = 1'b1;
            state_d = S_COMMIT;
          end else if (!cv_q && mode_q) begin
            mode_d  = 1'b0;
            state_d = S_RESEL;
          end else begin
            state_d = S_RUN;
          end
        end
      end
      S_COMMIT: begin
        if (last) begin
          state_d = S_OUT;
        end
      end
      S_RESEL: begin
        // back in low mode: any ready job
        if (en && h_status == ST_READY && (!cv_q || h_vd < vdm_q)) begin
          cur_d = hidx_q;
          cv_d  = 1'b1;
          vdm_d = h_vd;
        end
        if (last) begin
          state_d = S_RUN;
        end
      end
      S_RUN: begin
        if (last) begin
          state_d = S_OUT;
        end
      end
      S_LOAD: begin
        primed_d = 1'b1;
        if (!idx_ok) begin
          state_d = S_OUT;
        end else if (ctl.load_wr) begin
          if (cv_q && ld_hit && hit) begin
            cv_d = 1'b0;
          end
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        // time advances after the result of a tick
        if (ld_op_q == OP_TICK) begin
          now_d = now_q + TW'(1);
          if (!stale_q) begin
            rem_d = ((now_q == '1) || (17'(rem_q) + 17'd1 == 17'(quantum_q))) ?
                    16'd0 : rem_q + 16'd1;
          end
        end
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase

    if (cfg_valid_i && cfg_index_i == CFG_QUANTUM) begin
      stale_d = 1'b1;
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      hidx_q    <= '0;
      now_q     <= '0;
      rem_q     <= '0;
      stale_q   <= 1'b0;
      mode_q    <= 1'b0;
      cv_q      <= 1'b0;
      cur_q     <= '0;
      primed_q  <= 1'b0;
      dem_q     <= 1'b0;
      mv_q      <= 1'b0;
      m_q       <= '0;
      old_q     <= '0;
      oldv_q    <= 1'b0;
      quantum_q <= 16'd1;
      lambda_q  <= 17'h10000;
      tcount_q  <= 5'd1;
      for (int k = 0; k < CNT_NUM; k++) begin
        cnt_q[k] <= '0;
      end
    end else begin
      state_q  <= state_d;
      hidx_q   <= hidx_d;
      now_q    <= now_d;
      rem_q    <= rem_d;
      stale_q  <= stale_d;
      mode_q   <= mode_d;
      cv_q     <= cv_d;
      cur_q    <= cur_d;
      primed_q <= primed_d;
      dem_q    <= dem_d;
      mv_q     <= mv_d;
      m_q      <= m_d;
      old_q    <= old_d;
      oldv_q   <= oldv_d;
      for (int k = 0; k < CNT_NUM; k++) begin
        cnt_q[k] <= cnt_d[k];
      end
      if (cfg_valid_i) begin
        case (cfg_index_i)
          CFG_QUANTUM: quantum_q <= cfg_data_i[15:0];
          CFG_LAMBDA:  lambda_q  <= cfg_data_i;
          CFG_TCOUNT:  tcount_q  <= cfg_data_i[4:0];
          default:     tcount_q  <= tcount_q;
        endcase
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      ld_op_q     <= op_i;
      ld_idx_q    <= task_index_i;
      ld_period_q <= (period_i == 16'd0) ? 16'd1 : period_i;
      ld_budget_q <= low_budget_i;
      ld_high_q   <= high_crit_i;
      ld_done_q   <= running_done_i;
    end
    cx_exec_q   <= cx_exec_d;
    cx_budget_q <= cx_budget_d;
    cx_hd_q     <= cx_hd_d;
    cx_high_q   <= cx_high_d;
    cx_vd_q     <= cx_vd_d;
    vdm_q       <= vdm_d;
    scaled_q    <= prod[32:16];
  end

  // Result ports
  assign busy_o          = (state_q != S_IDLE);
  assign cfg_ready_o     = 1'b1;
  assign valid_o         = (state_q == S_OUT);
  assign running_valid_o = cv_q;
  assign running_task_o  = cv_q ? 4'(cur_q) : 4'd0;
  assign high_mode_o     = mode_q;
  assign done_low_o      = cnt_q[CNT_DONE_LOW];
  assign done_high_o     = cnt_q[CNT_DONE_HIGH];
  assign missed_low_o    = cnt_q[CNT_MISSED_LOW];
  assign missed_high_o   = cnt_q[CNT_MISSED_HIGH];
  assign switch_count_o  = cnt_q[CNT_SWITCH];

endmodule

[tb/edf_vd_mixed_criticality_scheduler_test.sv]
// ----------------------------------------------------------------------------
// EDF-VD mixed-criticality scheduler testbench
// Loads task tables and feeds time ticks under several configurations. A
// cycle-free model of the scheduler predicts the status after every item and
// the monitor checks each result, field by field, in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module edf_vd_mixed_criticality_scheduler_test;
  import edfvd_pkg::*;

  localparam int NT = 16;
  localparam int SETTLE = 7 * NT + 2 + 32 + 2 + 16;
  localparam int STALL_LIMIT = 4000;

  typedef struct packed {
    logic        op;
    logic [3:0]  idx;
    logic [15:0] period;
    logic [15:0] budget;
    logic        hc;
    logic        done;
  } sched_item_t;

  typedef struct packed {
    logic        rv;
    logic [3:0]  rt;
    logic        hm;
    logic [31:0] c_done_low;
    logic [31:0] c_done_high;
    logic [31:0] c_missed_low;
    logic [31:0] c_missed_high;
    logic [31:0] c_switch;
  } sched_status_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start_i = 1'b0;
  logic op_i = 1'b0;
  logic [3:0] task_index_i = '0;
  logic [15:0] period_i = '0;
  logic [15:0] low_budget_i = '0;
  logic high_crit_i = 1'b0;
  logic running_done_i = 1'b0;
  logic cfg_valid_i = 1'b0;
  logic [1:0] cfg_index_i = '0;
  logic [16:0] cfg_data_i = '0;
  logic busy_o, cfg_ready_o, valid_o, running_valid_o, high_mode_o;
  logic [3:0] running_task_o;
  logic [31:0] done_low_o, done_high_o, missed_low_o, missed_high_o, switch_count_o;

  edf_vd_mixed_criticality_scheduler uut (.*);

  always #4 clk_i = ~clk_i;

  // Scheduler state as predicted
  logic [15:0] tk_period [NT];
  logic [15:0] tk_budget [NT];
  logic        tk_high   [NT];
  logic [1:0]  job_st    [NT];
  logic [15:0] job_exec  [NT];
  logic [31:0] job_rel   [NT];
  logic [31:0] job_dl    [NT];
  logic [31:0] job_vd    [NT];
  logic [31:0] sim_now = '0;
  logic        hi_mode = 1'b0;
  logic        run_valid = 1'b0;
  logic [3:0]  run_idx = '0;
  logic [31:0] tally [CNT_NUM];
  logic [15:0] cf_quantum = 16'd1;
  logic [16:0] cf_lambda = 17'd65536;
  logic [4:0]  cf_count = 5'd1;

  sched_item_t   pending_items[$];
  sched_status_t status_q[$];
  int n_loads = 0, n_ticks = 0, n_checked = 0, n_errors = 0, n_hi = 0;
  bit gaps_on = 1'b1;
  int idle_cycles = 0;

  initial for (int k = 0; k < CNT_NUM; k++) tally[k] = '0;

  function automatic void tally_add(int k, logic [1:0] by);
    logic [32:0] s;
    s = {1'b0, tally[k]} + 33'(by);
    tally[k] = s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

  function automatic logic [31:0] vd_scaled(int i);
    logic [63:0] p;
    p = (64'(tk_period[i]) * 64'(cf_lambda)) >> 16;
    return job_rel[i] + p[31:0];
  endfunction

  function automatic void retire_job(int i, bit ok);
    tally_add((ok ? CNT_DONE_LOW : CNT_MISSED_LOW) + (tk_high[i] ? 1 : 0), 2'd1);
    job_st[i] = ST_IDLE;
    job_rel[i] = job_rel[i] + 32'(tk_period[i]);
    job_exec[i] = '0;
  endfunction

  function automatic void schedule_pass(bit done);
    int n;
    bit mv;
    int m;
    n = (cf_count > NT) ? NT : int'(cf_count);
    tally_add(CNT_SWITCH, 2'd2);
    if (run_valid && done) begin
      retire_job(run_idx, 1'b1);
      run_valid = 1'b0;
    end
    // overrun of the low budget: switch to high mode, drop low jobs
    if (run_valid && !hi_mode && job_exec[run_idx] > tk_budget[run_idx]) begin
      hi_mode = 1'b1;
      for (int i = 0; i < n; i++) begin
        if (job_st[i] == ST_IDLE) continue;
        if (tk_high[i]) job_vd[i] = job_rel[i] + 32'(tk_period[i]);
        else begin
          retire_job(i, 1'b0);
          if (run_valid && i == run_idx) run_valid = 1'b0;
        end
      end
    end
    // late jobs
    for (int i = 0; i < n; i++) begin
      if ((job_st[i] == ST_READY || job_st[i] == ST_RUN) && sim_now > job_dl[i]) begin
        retire_job(i, 1'b0);
        if (run_valid && i == run_idx) run_valid = 1'b0;
      end
    end
    // releases
    for (int i = 0; i < n; i++) begin
      if (job_st[i] == ST_IDLE && sim_now >= job_rel[i]) begin
        if (hi_mode && !tk_high[i]) retire_job(i, 1'b0);
        else begin
          job_st[i] = ST_READY;
          if (!hi_mode && tk_high[i]) job_vd[i] = vd_scaled(i);
          else job_vd[i] = job_rel[i] + 32'(tk_period[i]);
          job_dl[i] = job_rel[i] + 32'(tk_period[i]);
        end
      end
    end
    if (hi_mode && run_valid && !tk_high[run_idx]) begin
      job_st[run_idx] = ST_READY;
      run_valid = 1'b0;
    end
    // earliest scheduling deadline
    mv = run_valid;
    m = run_idx;
    for (int i = 0; i < n; i++) begin
      if (job_st[i] == ST_READY && (!hi_mode || tk_high[i]) &&
          (!mv || job_vd[i] < job_vd[m])) begin
        mv = 1'b1;
        m = i;
      end
    end
    if (mv && (!run_valid || m != run_idx)) begin
      if (run_valid) job_st[run_idx] = ST_READY;
      job_st[m] = ST_RUN;
      run_idx = m;
      run_valid = 1'b1;
    end
    // nothing left in high mode: back to low
    if (!run_valid && hi_mode) begin
      hi_mode = 1'b0;
      for (int i = 0; i < n; i++) begin
        if (job_st[i] == ST_READY && (!run_valid || job_vd[i] < job_vd[run_idx])) begin
          run_idx = i;
          run_valid = 1'b1;
        end
      end
      if (run_valid) job_st[run_idx] = ST_RUN;
    end
  endfunction

  function automatic sched_status_t predict_status(sched_item_t it);
    sched_status_t r;
    int i;
    bit boundary, trig;
    if (it.op == OP_LOAD) begin
      i = it.idx;
      tk_period[i] = (it.period == 0) ? 16'd1 : it.period;
      tk_budget[i] = it.budget;
      tk_high[i] = it.hc;
      if (run_valid && run_idx == i) run_valid = 1'b0;
      job_st[i] = ST_READY;
      job_exec[i] = '0;
      job_rel[i] = sim_now;
      job_dl[i] = sim_now + 32'(tk_period[i]);
      job_vd[i] = tk_high[i] ? vd_scaled(i) : job_dl[i];
    end else begin
      boundary = (cf_quantum == 0) || (sim_now % cf_quantum == 0);
      trig = run_valid && (it.done || (!hi_mode && job_exec[run_idx] > tk_budget[run_idx])
             || sim_now > job_dl[run_idx]);
      if (boundary || trig) schedule_pass(it.done);
      if (run_valid && job_exec[run_idx] != 16'hFFFF) job_exec[run_idx]++;
    end
    r.rv = run_valid;
    r.rt = run_valid ? run_idx : 4'd0;
    r.hm = hi_mode;
    r.c_done_low = tally[CNT_DONE_LOW];
    r.c_done_high = tally[CNT_DONE_HIGH];
    r.c_missed_low = tally[CNT_MISSED_LOW];
    r.c_missed_high = tally[CNT_MISSED_HIGH];
    r.c_switch = tally[CNT_SWITCH];
    if (it.op == OP_TICK) sim_now++;
    return r;
  endfunction

  // Driver: presents pending items, with random idle bursts
  sched_item_t cur_item;
  int gap_left = 0;
  always @(posedge clk_i or negedge rst_ni) begin
    bit take;
    if (!rst_ni) begin
      start_i <= 1'b0;
    end else begin
      take = start_i && !busy_o;
      if (take) begin
        status_q.push_back(predict_status(cur_item));
        if (cur_item.op == OP_LOAD) n_loads++;
        else n_ticks++;
      end
      if (!(start_i && !take)) begin
        if (gap_left > 0) begin
          gap_left--;
          start_i <= 1'b0;
        end else if (pending_items.size() > 0 && gaps_on && $urandom_range(0, 5) == 0) begin
          gap_left = $urandom_range(0, 3);
          start_i <= 1'b0;
        end else if (pending_items.size() > 0) begin
          cur_item = pending_items.pop_front();
          op_i <= cur_item.op;
          task_index_i <= cur_item.idx;
          period_i <= cur_item.period;
          low_budget_i <= cur_item.budget;
          high_crit_i <= cur_item.hc;
          running_done_i <= cur_item.done;
          start_i <= 1'b1;
        end else begin
          start_i <= 1'b0;
        end
      end
    end
  end

  // Monitor: every strobed result against the oldest prediction
  always @(posedge clk_i) begin
    sched_status_t exp_s, got;
    if (rst_ni && valid_o) begin
      got = {running_valid_o, running_task_o, high_mode_o, done_low_o, done_high_o,
             missed_low_o, missed_high_o, switch_count_o};
      if (status_q.size() == 0) begin
        n_errors++;
        if (n_errors <= 10) $display("ERROR: unexpected result %h", got);
      end else begin
        exp_s = status_q.pop_front();
        n_checked++;
        if (got.hm) n_hi++;
        if (got !== exp_s) begin
          n_errors++;
          if (n_errors <= 10) begin
            $display("ERROR: result %0d rv %b/%b task %0d/%0d hm %b/%b (exp/got)",
                     n_checked, exp_s.rv, got.rv, exp_s.rt, got.rt, exp_s.hm, got.hm);
            $display("  dl %0d/%0d dh %0d/%0d ml %0d/%0d mh %0d/%0d sw %0d/%0d",
                     exp_s.c_done_low, got.c_done_low, exp_s.c_done_high, got.c_done_high,
                     exp_s.c_missed_low, got.c_missed_low, exp_s.c_missed_high,
                     got.c_missed_high, exp_s.c_switch, got.c_switch);
          end
        end
      end
    end
  end

  // Watchdog on cycles with no item taken and no result
  always @(posedge clk_i) begin
    if (!rst_ni || (start_i && !busy_o) || valid_o) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("ERROR: no progress for %0d cycles", STALL_LIMIT);
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic write_reg(logic [1:0] idx, logic [16:0] val);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(negedge clk_i); while (!cfg_ready_o);
    @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    case (idx)
      CFG_QUANTUM: cf_quantum = val[15:0];
      CFG_LAMBDA:  cf_lambda = val;
      default:     cf_count = val[4:0];
    endcase
  endtask

  task automatic drain_block();
    while (pending_items.size() > 0 || status_q.size() > 0 || start_i) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  function automatic sched_item_t mk_item(bit op, int idx, int per, int bud, bit hc, bit dn);
    sched_item_t it;
    it.op = op;
    it.idx = 4'(idx);
    it.period = 16'(per);
    it.budget = 16'(bud);
    it.hc = hc;
    it.done = dn;
    return it;
  endfunction

  function automatic sched_item_t rand_item();
    int per, bud;
    if ($urandom_range(0, 9) == 0) begin
      per = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 65535) : $urandom_range(1, 30);
      bud = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 65535) : $urandom_range(0, per);
      return mk_item(OP_LOAD, $urandom_range(0, 15), per, bud, $urandom_range(0, 1),
                     $urandom_range(0, 1));
    end
    return mk_item(OP_TICK, $urandom, $urandom, $urandom, $urandom_range(0, 1),
                   $urandom_range(0, 3) == 0);
  endfunction

  // Phase settings: quantum, lambda, task count
  int ph_q[7] = '{1, 0, 3, 65535, 5, 2, 1};
  int ph_l[7] = '{65536, 32768, 1, 65536, 131071, 45000, 20000};
  int ph_c[7] = '{16, 4, 8, 2, 31, 0, 16};

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);
    // directed: fill the whole table, extremes of the fields, zero period
    for (int i = 0; i < NT; i++)
      pending_items.push_back(mk_item(OP_LOAD, i,
          (i == 0) ? 0 : (i == 1) ? 65535 : 2 + i,
          (i == 1) ? 65535 : (i == 2) ? 0 : i % 4, i % 2, i % 3 == 0));
    for (int k = 0; k < 7; k++)
      pending_items.push_back(mk_item(OP_TICK, 15, 65535, 65535, 1'b1, k % 3 == 2));
    pending_items.push_back(mk_item(OP_LOAD, 0, 4, 1, 1'b1, 1'b0));
    drain_block();
    // random phases under several settings
    for (int p = 0; p < 7; p++) begin
      write_reg(CFG_QUANTUM, 17'(ph_q[p]));
      write_reg(CFG_LAMBDA, 17'(ph_l[p]));
      write_reg(CFG_TCOUNT, 17'(ph_c[p]));
      if (p == 6) gaps_on = 1'b0;
      for (int k = 0; k < 175; k++) pending_items.push_back(rand_item());
      drain_block();
    end
    $display("Ran %0d loads and %0d ticks over 8 settings; %0d results checked.",
             n_loads, n_ticks, n_checked);
    $display("High mode was shown in %0d results.", n_hi);
    if (n_errors == 0 && status_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches, %0d results outstanding", n_errors, status_q.size());
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/edfvd_pkg.sv
rtl/edfvd_cell.sv
rtl/edfvd_head.sv
rtl/edfvd_rem.sv
rtl/edf_vd_mixed_criticality_scheduler.sv
tb/edf_vd_mixed_criticality_scheduler_test.sv
